[rtl/core/lrp_pkg.sv]
// Shared types and constants for the location record parser.
package lrp_pkg;

    localparam logic [7:0] REC_VERSION     = 8'd1;
    localparam logic [5:0] REC_BASE_LEN    = 6'd10;
    localparam logic [7:0] REC_KNOWN_FLAGS = 8'h3F;
    localparam logic [5:0] COUNT_MAX       = 6'd63;
    localparam logic [5:0] FIXED_HDR_LEN   = 6'd4;
    localparam int         SLOT_COUNT      = 8;

    localparam logic [5:0] POS_VERSION  = 6'd0;
    localparam logic [5:0] POS_FLAGS    = 6'd1;
    localparam logic [5:0] POS_FIX      = 6'd2;
    localparam logic [5:0] POS_RESERVED = 6'd3;

    localparam logic [2:0] SLOT_LAT  = 3'd0;
    localparam logic [2:0] SLOT_LON  = 3'd1;
    localparam logic [2:0] SLOT_ALT  = 3'd2;
    localparam logic [2:0] SLOT_TIME = 3'd3;
    localparam logic [2:0] SLOT_SATS = 3'd4;
    localparam logic [2:0] SLOT_HACC = 3'd5;
    localparam logic [2:0] SLOT_VACC = 3'd6;
    localparam logic [2:0] SLOT_AGE  = 3'd7;

    localparam logic [1:0] ST_ACCEPTED    = 2'd0;
    localparam logic [1:0] ST_BAD_REQUEST = 2'd1;
    localparam logic [1:0] ST_FORBIDDEN   = 2'd2;

    typedef struct packed {
        logic       hit;
        logic       is_end;
        logic [2:0] slot;
        logic [5:0] expected_len;
    } slot_info_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         fields_present;
        logic [7:0]         fix_mode;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
        logic [31:0]        fix_time;
        logic [7:0]         satellites;
        logic [31:0]        horizontal_accuracy;
        logic [31:0]        vertical_accuracy;
        logic [31:0]        fix_age;
    } rec_result_t;

endpackage

[rtl/core/lrp_slot_map.sv]
// Maps a body byte offset onto its field slot and computes the expected record length.
module lrp_slot_map (
    input  logic [5:0]          flags,
    input  logic [5:0]          pos,
    output lrp_pkg::slot_info_t info
);
    import lrp_pkg::*;

    logic [5:0] offset;
    logic [5:0] start;
    logic [2:0] len;

    assign offset = pos - FIXED_HDR_LEN;

    always_comb
    begin
        info  = '0;
        start = '0;
        len   = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (k < 2)
                len = 3'd4;
            else if (!flags[k - 2])
                len = 3'd0;
            else if (3'(k) == SLOT_SATS)
                len = 3'd1;
            else
                len = 3'd4;
            if (len != 3'd0 && offset >= start && offset < start + {3'b0, len})
            begin
                info.hit    = 1'b1;
                info.slot   = 3'(k);
                info.is_end = (offset == start + {3'b0, len} - 6'd1);
            end
            start = start + {3'b0, len};
        end
        info.expected_len = FIXED_HDR_LEN + start;
    end

endmodule

[rtl/core/lrp_record_state.sv]
// Per-record parse state: header checks, field assembly and result evaluation.
module lrp_record_state (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           payload_byte,
    input  logic                 last_byte,
    input  logic                 source_local,
    output lrp_pkg::rec_result_t result
);
    import lrp_pkg::*;

    logic [5:0]  count_reg, count_next, count_inc;
    logic        version_good_reg, version_good_next;
    logic [7:0]  flag_bits_reg, flag_bits_next;
    logic [7:0]  fix_byte_reg, fix_byte_next;
    logic        reserved_zero_reg, reserved_zero_next;
    logic        local_latch_reg, local_latch_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [31:0] store_reg [SLOT_COUNT];
    logic [31:0] store_next [SLOT_COUNT];
    logic [31:0] shifted;
    slot_info_t  info;
    logic        len_bad;

    lrp_slot_map u_slot_map (
        .flags (flag_bits_reg[5:0]),
        .pos   (count_reg),
        .info  (info)
    );

    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 6'd1 : COUNT_MAX;
    assign shifted   = {word_shift_reg[23:0], payload_byte};

    always_comb
    begin
        version_good_next  = version_good_reg;
        flag_bits_next     = flag_bits_reg;
        fix_byte_next      = fix_byte_reg;
        reserved_zero_next = reserved_zero_reg;
        local_latch_next   = local_latch_reg;
        word_shift_next    = word_shift_reg;
        for (int k = 0; k < SLOT_COUNT; k++)
            store_next[k] = store_reg[k];
        priority if (count_reg == POS_VERSION)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
                store_next[k] = '0;
            word_shift_next    = '0;
            flag_bits_next     = '0;
            fix_byte_next      = '0;
            reserved_zero_next = 1'b1;
            local_latch_next   = source_local;
            version_good_next  = (payload_byte == REC_VERSION);
        end
        else if (count_reg == POS_FLAGS)
            flag_bits_next = payload_byte;
        else if (count_reg == POS_FIX)
            fix_byte_next = payload_byte;
        else if (count_reg == POS_RESERVED)
            reserved_zero_next = (payload_byte == 8'd0);
        else
        begin
            if (count_reg < COUNT_MAX && info.hit)
            begin
                word_shift_next = shifted;
                if (info.is_end)
                begin
                    store_next[info.slot] = shifted;
                    word_shift_next       = '0;
                end
            end
        end
        count_next = last_byte ? 6'd0 : count_inc;
    end

    assign len_bad = ((flag_bits_next & ~REC_KNOWN_FLAGS) != 8'd0) || !reserved_zero_next
                     || (count_inc != info.expected_len);

    always_comb
    begin
        result = '0;
        priority if (count_inc < REC_BASE_LEN || !version_good_next)
            result.status = ST_BAD_REQUEST;
        else if (!local_latch_next)
            result.status = ST_FORBIDDEN;
        else if (len_bad)
            result.status = ST_BAD_REQUEST;
        else
            result.status = ST_ACCEPTED;
        if (result.status == ST_ACCEPTED)
        begin
            result.fields_present      = flag_bits_next[5:0];
            result.fix_mode            = fix_byte_next;
            result.latitude            = store_next[SLOT_LAT];
            result.longitude           = store_next[SLOT_LON];
            result.altitude            = store_next[SLOT_ALT];
            result.fix_time            = store_next[SLOT_TIME];
            result.satellites          = store_next[SLOT_SATS][7:0];
            result.horizontal_accuracy = store_next[SLOT_HACC];
            result.vertical_accuracy   = store_next[SLOT_VACC];
            result.fix_age             = store_next[SLOT_AGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            version_good_reg  <= 1'b0;
            flag_bits_reg     <= '0;
            fix_byte_reg      <= '0;
            reserved_zero_reg <= 1'b1;
            local_latch_reg   <= 1'b0;
            word_shift_reg    <= '0;
        end
        else if (step)
        begin
            count_reg         <= count_next;
            version_good_reg  <= version_good_next;
            flag_bits_reg     <= flag_bits_next;
            fix_byte_reg      <= fix_byte_next;
            reserved_zero_reg <= reserved_zero_next;
            local_latch_reg   <= local_latch_next;
            word_shift_reg    <= word_shift_next;
        end
    end

    // cleared on the first byte of every record
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
                store_reg[k] <= store_next[k];
        end
    end

endmodule

[rtl/core/location_record_parser_unit.sv]
// Location record parser top level: input register, parse state and result register.
//
// Usage:
//   Byte channel: payload_byte, last_byte, source_local with byte_valid and
//   byte_stall; a request is taken at an edge where byte_valid is high and
//   byte_stall is low. source_local is sampled on the first byte of a record.
//   Result channel: status and the decoded fields with result_valid and
//   result_stall; one result per record, on its last byte.
//   Throughput: one byte per cycle while byte_stall is low. Bytes that are
//   not last never wait on the result side.
//   Path: a last byte that is taken passes the input register and then the
//   result register, which drives result_valid.
//   Stall: while result_stall holds a result, a last byte waiting in the
//   input register holds there and byte_stall rises; non-last bytes in
//   flight keep moving.
//   Reset: clears the valid bits of both registers and the record state apart
//   from the field store; the first byte after reset starts a new record.
//   Rejected records report every field other than status as zero.
module location_record_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         payload_byte,
    input  logic               last_byte,
    input  logic               source_local,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         status,
    output logic [5:0]         fields_present,
    output logic [7:0]         fix_mode,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic signed [31:0] altitude,
    output logic [31:0]        fix_time,
    output logic [7:0]         satellites,
    output logic [31:0]        horizontal_accuracy,
    output logic [31:0]        vertical_accuracy,
    output logic [31:0]        fix_age
);
    import lrp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_src_reg;
    logic        out_valid_reg;
    rec_result_t out_reg;
    rec_result_t result;
    logic        out_free;
    logic        advance;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && (!in_last_reg || out_free);
    assign byte_stall = in_valid_reg && !advance;

    lrp_record_state u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .payload_byte (in_byte_reg),
        .last_byte    (in_last_reg),
        .source_local (in_src_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_byte_reg <= payload_byte;
            in_last_reg <= last_byte;
            in_src_reg  <= source_local;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_reg <= result;
    end

    assign result_valid        = out_valid_reg;
    assign status              = out_reg.status;
    assign fields_present      = out_reg.fields_present;
    assign fix_mode            = out_reg.fix_mode;
    assign latitude            = out_reg.latitude;
    assign longitude           = out_reg.longitude;
    assign altitude            = out_reg.altitude;
    assign fix_time            = out_reg.fix_time;
    assign satellites          = out_reg.satellites;
    assign horizontal_accuracy = out_reg.horizontal_accuracy;
    assign vertical_accuracy   = out_reg.vertical_accuracy;
    assign fix_age             = out_reg.fix_age;

`ifndef ASSERT_OFF
    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (in_valid_reg && in_last_reg && out_valid_reg && result_stall))
        else $error("byte channel stalled without a held last byte");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(advance && in_last_reg))
        else $error("result raised without a last byte");

    a_reject_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_ACCEPTED) |->
        (fields_present == 6'd0 && fix_mode == 8'd0 && latitude == 32'sd0
         && longitude == 32'sd0 && fix_age == 32'd0))
        else $error("rejected record carries field data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ST_ACCEPTED || status == ST_BAD_REQUEST
                          || status == ST_FORBIDDEN))
        else $error("undefined status code");
`endif

endmodule
